@@ rtl/lsbp_pkg.sv @@
package lsbp_pkg;

	localparam int MAX_MARKERS = 4096;
	localparam int IDX_W       = 12;
	localparam int CNT_W       = 13;
	localparam int DP_W        = 17;
	localparam int CFG_W       = 17;
	localparam int CFG_IDX_W   = 2;

	// result queue
	localparam int Q_DEPTH = 8;
	localparam int Q_PTR_W = $clog2(Q_DEPTH);
	localparam int Q_CNT_W = Q_PTR_W + 1;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_MARKER_COUNT  = 2'd0,
		CFG_LD_THRESHOLD  = 2'd1,
		CFG_MIN_BLOCK_LEN = 2'd2
	} cfg_idx_t;

	typedef struct packed {
		logic [IDX_W-1:0] row_index;
		logic [IDX_W-1:0] col_index;
		logic [DP_W-1:0]  dprime_value;
	} item_t;

	typedef struct packed {
		logic [IDX_W-1:0] block_first;
		logic [IDX_W-1:0] block_last;
		logic             last_of_run;
	} result_t;

	// zero, one or two results produced by one item
	typedef struct packed {
		logic [1:0] num;
		result_t    r0;
		result_t    r1;
	} push_t;

endpackage

@@ rtl/lsbp_if.sv @@
interface lsbp_in_if;
	import lsbp_pkg::*;

	logic             valid;
	logic             ready;
	logic [IDX_W-1:0] row_index;
	logic [IDX_W-1:0] col_index;
	logic [DP_W-1:0]  dprime_value;

	modport source (output valid, output row_index, output col_index, output dprime_value,
		input ready);
	modport sink (input valid, input row_index, input col_index, input dprime_value,
		output ready);
endinterface

interface lsbp_out_if;
	import lsbp_pkg::*;

	logic             valid;
	logic             ready;
	logic [IDX_W-1:0] block_first;
	logic [IDX_W-1:0] block_last;
	logic             last_of_run;

	modport source (output valid, output block_first, output block_last, output last_of_run,
		input ready);
	modport sink (input valid, input block_first, input block_last, input last_of_run,
		output ready);
endinterface

@@ rtl/ld_spine_block_partition.sv @@
// LD block partition over a streamed upper-triangular |D'| matrix.
//
// in_ch   : one matrix entry per item (row_index, col_index, dprime_value),
//           column by column, rows rising inside a column.
// out_ch  : one reported block per item (block_first, block_last inclusive,
//           last_of_run set on the final block caused by one entry).
// cfg     : cfg_we / cfg_index / cfg_data write marker_count, ld_threshold
//           and min_block_len; write them only while the block is idle.
//
// Timing: an entry is registered at acceptance and its blocks are written
// into the result queue on the next edge; a block is on out_ch once it is
// in the queue, and never while its entry is being accepted.
// Throughput: one entry per cycle. Most entries yield nothing; an entry that
// closes a column can yield one or two blocks, which go into an 8-deep
// result queue. in_ch.ready drops only when the queue plus the entry in
// flight could overflow, so a stalled receiver backs up into the input.
// Reset: block start and column flag clear, registers take their defaults
// (marker_count 0, ld_threshold 52429, min_block_len 2), queue empties.
module ld_spine_block_partition (
	input  logic                        clk,
	input  logic                        arst_n,
	lsbp_in_if.sink                     in_ch,
	lsbp_out_if.source                  out_ch,
	input  logic                        cfg_we,
	input  logic [lsbp_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [lsbp_pkg::CFG_W-1:0]  cfg_data
);
	import lsbp_pkg::*;

	logic [CNT_W-1:0]   marker_count_q;
	logic [DP_W-1:0]    ld_threshold_q;
	logic [CNT_W-1:0]   min_block_len_q;

	item_t              item;
	push_t              push;
	result_t            head;
	logic               busy;
	logic               take;
	logic               pop;
	logic [Q_CNT_W-1:0] q_count;
	logic [Q_CNT_W:0]   q_need;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			marker_count_q  <= '0;
			ld_threshold_q  <= DP_W'(52429);
			min_block_len_q <= CNT_W'(2);
		end else if (cfg_we) begin
			case (cfg_idx_t'(cfg_index))
				CFG_MARKER_COUNT:  marker_count_q  <= cfg_data[CNT_W-1:0];
				CFG_LD_THRESHOLD:  ld_threshold_q  <= cfg_data[DP_W-1:0];
				CFG_MIN_BLOCK_LEN: min_block_len_q <= cfg_data[CNT_W-1:0];
				default: ;
			endcase
		end
	end

	// room for two blocks from the entry in flight and two from a new one
	assign q_need = {1'b0, q_count} + (busy ? (Q_CNT_W+1)'(2) : '0);
	assign in_ch.ready = q_need <= (Q_CNT_W+1)'(Q_DEPTH - 2);
	assign take = in_ch.valid && in_ch.ready;

	assign item.row_index    = in_ch.row_index;
	assign item.col_index    = in_ch.col_index;
	assign item.dprime_value = in_ch.dprime_value;

	lsbp_part u_part (
		.clk           (clk),
		.arst_n        (arst_n),
		.take          (take),
		.item          (item),
		.marker_count  (marker_count_q),
		.ld_threshold  (ld_threshold_q),
		.min_block_len (min_block_len_q),
		.busy          (busy),
		.push          (push)
	);

	assign pop = out_ch.valid && out_ch.ready;

	lsbp_fifo u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.pop    (pop),
		.count  (q_count),
		.head   (head)
	);

	assign out_ch.valid       = q_count != '0;
	assign out_ch.block_first = head.block_first;
	assign out_ch.block_last  = head.block_last;
	assign out_ch.last_of_run = head.last_of_run;

endmodule

@@ rtl/lsbp_part.sv @@
module lsbp_part (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    take,
	input  lsbp_pkg::item_t         item,
	input  logic [lsbp_pkg::CNT_W-1:0] marker_count,
	input  logic [lsbp_pkg::DP_W-1:0]  ld_threshold,
	input  logic [lsbp_pkg::CNT_W-1:0] min_block_len,
	output logic                    busy,
	output lsbp_pkg::push_t         push
);
	import lsbp_pkg::*;

	logic             valid_s1;
	item_t            item_s1;
	logic [IDX_W-1:0] block_start_q;
	logic             column_failed_q;

	logic [CNT_W-1:0] n;
	logic [CNT_W-1:0] col_w;
	logic [CNT_W-1:0] row_w;
	logic             in_range;
	logic             failed;
	logic             end_col;
	logic             flush;
	logic             close_ok;
	logic             flush_ok;
	logic [IDX_W-1:0] start2;
	logic [CNT_W-1:0] close_len;
	logic [CNT_W-1:0] flush_len;
	logic [IDX_W-1:0] n_last;
	result_t          close_r;
	result_t          flush_r;

	assign busy = valid_s1;

	always_comb begin
		n = (marker_count > CNT_W'(MAX_MARKERS)) ? CNT_W'(MAX_MARKERS) : marker_count;
		col_w = {1'b0, item_s1.col_index};
		row_w = {1'b0, item_s1.row_index};
		in_range = (n >= CNT_W'(2)) && (item_s1.col_index != '0) && (col_w < n)
			&& (item_s1.row_index < item_s1.col_index);
		failed = column_failed_q
			|| ((item_s1.row_index >= block_start_q) && (item_s1.dprime_value < ld_threshold));
		end_col = (row_w + CNT_W'(1)) == col_w;
		flush = end_col && (col_w == n - CNT_W'(1));
		n_last = IDX_W'(n - CNT_W'(1));

		// closing block [block_start, col-1]
		close_len = col_w - {1'b0, block_start_q};
		close_ok = valid_s1 && in_range && end_col && failed && (min_block_len != '0)
			&& (block_start_q < item_s1.col_index) && (close_len >= min_block_len);
		start2 = (end_col && failed) ? item_s1.col_index : block_start_q;

		// flushed final block [start2, n-1]
		flush_len = n - {1'b0, start2};
		flush_ok = valid_s1 && in_range && flush && (min_block_len != '0)
			&& ({1'b0, start2} < n) && (flush_len >= min_block_len);

		close_r.block_first = block_start_q;
		close_r.block_last  = item_s1.col_index - IDX_W'(1);
		close_r.last_of_run = !flush_ok;
		flush_r.block_first = start2;
		flush_r.block_last  = n_last;
		flush_r.last_of_run = 1'b1;

		push.num = 2'(close_ok) + 2'(flush_ok);
		push.r0  = close_ok ? close_r : flush_r;
		push.r1  = flush_r;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1        <= 1'b0;
			block_start_q   <= '0;
			column_failed_q <= 1'b0;
		end else begin
			valid_s1 <= take;
			if (valid_s1 && in_range) begin
				column_failed_q <= failed;
				if (end_col && failed) begin
					block_start_q   <= item_s1.col_index;
					column_failed_q <= 1'b0;
				end
				if (flush) begin
					block_start_q   <= '0;
					column_failed_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			item_s1 <= item;
		end
	end

endmodule

@@ rtl/lsbp_fifo.sv @@
module lsbp_fifo (
	input  logic                      clk,
	input  logic                      arst_n,
	input  lsbp_pkg::push_t           push,
	input  logic                      pop,
	output logic [lsbp_pkg::Q_CNT_W-1:0] count,
	output lsbp_pkg::result_t         head
);
	import lsbp_pkg::*;

	result_t            mem [Q_DEPTH];
	logic [Q_PTR_W-1:0] wr_q;
	logic [Q_PTR_W-1:0] rd_q;
	logic [Q_CNT_W-1:0] count_q;

	assign count = count_q;
	assign head  = mem[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			wr_q    <= wr_q + Q_PTR_W'(push.num);
			rd_q    <= rd_q + Q_PTR_W'(pop);
			count_q <= count_q + Q_CNT_W'(push.num) - Q_CNT_W'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push.num != 2'd0) begin
			mem[wr_q] <= push.r0;
		end
		if (push.num == 2'd2) begin
			mem[wr_q + Q_PTR_W'(1)] <= push.r1;
		end
	end

endmodule

@@ test/lsbp_block_checker.sv @@
`timescale 1ns / 1ps

module lsbp_block_checker (
	input  logic                           clk,
	input  logic                           arst_n,
	lsbp_in_if                             in_ch,
	lsbp_out_if                            out_ch,
	input  logic                           cfg_we,
	input  logic [lsbp_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [lsbp_pkg::CFG_W-1:0]     cfg_data,
	output int                             blocks_pending,
	output int                             fail_count
);
	import lsbp_pkg::*;

	localparam int DEFAULT_THRESHOLD = 52429;
	localparam int DEFAULT_MIN_LEN   = 2;

	logic [CNT_W-1:0] marker_count;
	logic [DP_W-1:0]  ld_threshold;
	logic [CNT_W-1:0] min_block_len;
	int               span_start;
	logic             span_broken;
	result_t          block_q[$];

	// queue one block unless min_block_len is zero or the block is empty or too short
	function automatic void queue_block(input int blk_first, input int blk_last);
		result_t blk;
		if (min_block_len == '0 || blk_first > blk_last ||
				blk_last - blk_first + 1 < int'(min_block_len))
			return;
		blk.block_first = IDX_W'(blk_first);
		blk.block_last  = IDX_W'(blk_last);
		blk.last_of_run = 1'b0;
		block_q.push_back(blk);
	endfunction

	// blocks closed by one matrix entry
	function automatic void predict_blocks(input logic [IDX_W-1:0] row_index,
			input logic [IDX_W-1:0] col_index, input logic [DP_W-1:0] dprime_value);
		int      n;
		int      row;
		int      col;
		int      queued_prior;
		result_t tail;
		n   = (int'(marker_count) > MAX_MARKERS) ? MAX_MARKERS : int'(marker_count);
		row = int'(row_index);
		col = int'(col_index);
		if (n < 2 || col == 0 || col >= n || row >= col)
			return;
		queued_prior = block_q.size();
		if (row >= span_start && dprime_value < ld_threshold)
			span_broken = 1'b1;
		if (row + 1 == col) begin
			if (span_broken) begin
				queue_block(span_start, col - 1);
				span_start  = col;
				span_broken = 1'b0;
			end
			if (col == n - 1) begin
				queue_block(span_start, n - 1);
				span_start  = 0;
				span_broken = 1'b0;
			end
		end
		if (block_q.size() > queued_prior) begin
			tail = block_q.pop_back();
			tail.last_of_run = 1'b1;
			block_q.push_back(tail);
		end
	endfunction

	initial begin
		blocks_pending = 0;
		fail_count     = 0;
	end

	always @(posedge clk or negedge arst_n) begin
		result_t want;
		if (!arst_n) begin
			marker_count  = '0;
			ld_threshold  = DP_W'(DEFAULT_THRESHOLD);
			min_block_len = CNT_W'(DEFAULT_MIN_LEN);
			span_start    = 0;
			span_broken   = 1'b0;
			block_q.delete();
		end else begin
			if (out_ch.valid && out_ch.ready) begin
				if (block_q.size() == 0) begin
					$error("unexpected block [%0d, %0d]", out_ch.block_first, out_ch.block_last);
					fail_count++;
				end else begin
					want = block_q.pop_front();
					if (out_ch.block_first !== want.block_first) begin
						$error("block_first: expected %0d, got %0d",
							want.block_first, out_ch.block_first);
						fail_count++;
					end
					if (out_ch.block_last !== want.block_last) begin
						$error("block_last: expected %0d, got %0d",
							want.block_last, out_ch.block_last);
						fail_count++;
					end
					if (out_ch.last_of_run !== want.last_of_run) begin
						$error("last_of_run: expected %0d, got %0d",
							want.last_of_run, out_ch.last_of_run);
						fail_count++;
					end
				end
			end
			if (cfg_we) begin
				case (cfg_idx_t'(cfg_index))
					CFG_MARKER_COUNT:  marker_count  = cfg_data[CNT_W-1:0];
					CFG_LD_THRESHOLD:  ld_threshold  = cfg_data[DP_W-1:0];
					CFG_MIN_BLOCK_LEN: min_block_len = cfg_data[CNT_W-1:0];
					default: ;
				endcase
			end
			if (in_ch.valid && in_ch.ready)
				predict_blocks(in_ch.row_index, in_ch.col_index, in_ch.dprime_value);
		end
		blocks_pending = block_q.size();
	end

endmodule

@@ test/tb_top.sv @@
`timescale 1ns / 1ps

module tb_top;
	import lsbp_pkg::*;

	localparam int ITEM_GOAL     = 1500;  // well-formed entries in the random part
	localparam int IDLE_LIMIT    = 2000;  // cycles with no handshake on either side
	localparam int SETTLE_CYCLES = 4;     // extra wait after the queue drains, for entries with no result
	localparam int DP_MAX        = 131071;
	localparam int Q_ONE         = 65536; // 1.0 in Q1.16

	logic                 clk;
	logic                 arst_n;
	logic                 cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_W-1:0]     cfg_data;
	int                   blocks_pending;
	int                   fail_count;

	logic in_took;        // entry accepted at the last rising edge
	bit   steady;         // no gaps and no stalls for this phase
	int   stall_left;
	int   idle_cycles;
	int   cur_threshold;
	int   fail_pct;       // share of entries drawn below threshold
	int   items_sent;

	lsbp_in_if  in_ch();
	lsbp_out_if out_ch();

	ld_spine_block_partition u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_ch     (in_ch),
		.out_ch    (out_ch),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	// watches both channels and the register port, predicts and compares
	lsbp_block_checker u_checker (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_ch          (in_ch),
		.out_ch         (out_ch),
		.cfg_we         (cfg_we),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.blocks_pending (blocks_pending),
		.fail_count     (fail_count)
	);

	always #5ns clk = ~clk;

	// registered handshake: read by the driver at the falling edge, so it
	// never races the DUT's own update of ready
	always @(posedge clk) begin
		in_took <= in_ch.valid && in_ch.ready;
	end

	// watchdog: a hung DUT or a lost block ends the run here
	always @(posedge clk) begin
		if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

	// mostly short gaps, now and then a long one
	function automatic int pick_gap();
		if ($urandom_range(0, 99) < 85)
			return $urandom_range(1, 3);
		return $urandom_range(10, 60);
	endfunction

	// receiver back-pressure; ready changes at the falling edge only
	always @(negedge clk) begin
		if (steady) begin
			out_ch.ready <= 1'b1;
		end else if (stall_left > 0) begin
			out_ch.ready <= 1'b0;
			stall_left--;
		end else if ($urandom_range(0, 99) < 25) begin
			out_ch.ready <= 1'b0;
			stall_left = pick_gap() - 1;
		end else begin
			out_ch.ready <= 1'b1;
		end
	end

	// |D'| drawn around the current threshold; fail_pct sets how often a
	// column breaks, so block lengths vary from phase to phase
	function automatic int pick_dprime();
		if (cur_threshold > 0 && $urandom_range(0, 99) < fail_pct) begin
			case ($urandom_range(0, 2))
				0:       return 0;
				1:       return cur_threshold - 1;
				default: return $urandom_range(0, cur_threshold - 1);
			endcase
		end
		case ($urandom_range(0, 3))
			0:       return cur_threshold;
			1:       return Q_ONE;
			default: return $urandom_range(cur_threshold, DP_MAX);
		endcase
	endfunction

	// Called and returning at a falling edge. Valid is either lowered for a
	// gap or kept high with the next entry, never both in one step.
	task automatic send_entry(input int row, input int col, input int dprime);
		int gap;
		gap = (steady || $urandom_range(0, 99) < 65) ? 0 : pick_gap();
		if (gap > 0) begin
			in_ch.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_ch.valid        <= 1'b1;
		in_ch.row_index    <= IDX_W'(row);
		in_ch.col_index    <= IDX_W'(col);
		in_ch.dprime_value <= DP_W'(dprime);
		do @(negedge clk); while (!in_took);
	endtask

	// drain all expected blocks, then let entries with no result retire
	task automatic settle();
		in_ch.valid <= 1'b0;
		while (blocks_pending != 0) @(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic set_regs(input int count, input int threshold, input int min_len);
		cfg_we    <= 1'b1;
		cfg_index <= CFG_MARKER_COUNT;
		cfg_data  <= CFG_W'(count);
		@(negedge clk);
		cfg_index <= CFG_LD_THRESHOLD;
		cfg_data  <= CFG_W'(threshold);
		@(negedge clk);
		cfg_index <= CFG_MIN_BLOCK_LEN;
		cfg_data  <= CFG_W'(min_len);
		@(negedge clk);
		cfg_we        <= 1'b0;
		cur_threshold  = threshold;
	endtask

	// Column-major upper triangle, cut short after 'stop' entries. A few
	// entries are dropped and stray ones slipped in to break the order.
	task automatic send_matrix(input int n, input int stop);
		int sent;
		sent = 0;
		for (int col = 1; col < n; col++) begin
			for (int row = 0; row < col; row++) begin
				if (sent == stop)
					return;
				if ($urandom_range(0, 99) < 3)
					send_entry($urandom_range(0, 4095), $urandom_range(0, 4095),
						$urandom_range(0, DP_MAX));
				else if ($urandom_range(0, 99) < 3)
					send_entry($urandom_range(0, n), $urandom_range(0, n), pick_dprime());
				if ($urandom_range(0, 99) >= 3)
					send_entry(row, col, pick_dprime());
				sent++;
				items_sent++;
			end
		end
	endtask

	initial begin
		clk                = 1'b0;
		arst_n             = 1'b0;
		cfg_we             = 1'b0;
		cfg_index          = CFG_MARKER_COUNT;
		cfg_data           = '0;
		in_ch.valid        = 1'b0;
		in_ch.row_index    = '0;
		in_ch.col_index    = '0;
		in_ch.dprime_value = '0;
		out_ch.ready       = 1'b0;
		steady             = 1'b0;
		stall_left         = 0;
		idle_cycles        = 0;
		cur_threshold      = 52429;
		fail_pct           = 20;
		items_sent         = 0;

		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// --- directed ---
		// reset defaults: marker_count 0, too few markers, all ignored
		send_entry(0, 1, 0);
		send_entry(4094, 4095, DP_MAX);
		send_entry(0, 0, 0);

		// four markers, default threshold, one-marker blocks allowed
		settle();
		set_regs(4, 52429, 1);
		send_entry(0, 1, 60000);
		send_entry(0, 2, 100);          // breaks column 2
		send_entry(3, 3, 0);            // row not below column: ignored
		send_entry(1, 2, 60000);        // closes [0,1]
		send_entry(0, 3, 0);            // row before block start: no break
		send_entry(0, 4, 0);            // column past the last marker
		send_entry(1, 3, Q_ONE);
		send_entry(2, 3, 10);           // closes [2,2], flushes [3,3]

		// zero block length: the flush reports nothing
		settle();
		set_regs(2, 0, 0);
		send_entry(0, 1, 0);

		// single marker: no valid column at all
		settle();
		set_regs(1, Q_ONE, MAX_MARKERS);
		send_entry(0, 1, 0);

		// full size: the last entry alone flushes the whole range
		settle();
		set_regs(MAX_MARKERS, Q_ONE, MAX_MARKERS);
		send_entry(4094, 4095, Q_ONE);
		send_entry(4094, 4095, Q_ONE - 1);

		// out of order: a column closing before the block start is empty
		settle();
		set_regs(MAX_MARKERS, Q_ONE, 1);
		send_entry(5, 6, 0);
		send_entry(7, 9, 0);
		send_entry(2, 3, 0);

		// --- random phases ---
		while (items_sent < ITEM_GOAL) begin
			int n;
			int thr;
			int min_len;
			int pairs;
			case ($urandom_range(0, 19))
				0:       n = $urandom_range(0, 1);
				1:       n = $urandom_range(31, MAX_MARKERS);
				2, 3:    n = $urandom_range(15, 30);
				default: n = $urandom_range(2, 14);
			endcase
			case ($urandom_range(0, 5))
				0:       thr = 0;
				1:       thr = Q_ONE;
				2:       thr = 52429;
				default: thr = $urandom_range(0, Q_ONE);
			endcase
			case ($urandom_range(0, 9))
				0:       min_len = 0;
				1:       min_len = MAX_MARKERS;
				2:       min_len = n;
				default: min_len = $urandom_range(1, 4);
			endcase
			settle();
			set_regs(n, thr, min_len);
			fail_pct = $urandom_range(1, 40);
			steady   = ($urandom_range(0, 4) == 0);
			pairs    = n * (n - 1) / 2;
			if (n < 2) begin
				repeat (3)
					send_entry($urandom_range(0, 4095), $urandom_range(0, 4095),
						$urandom_range(0, DP_MAX));
			end else if (n > 30) begin
				// large matrix: only its head, then the final entry
				send_matrix(n, $urandom_range(1, 150));
				send_entry(n - 2, n - 1, pick_dprime());
				items_sent++;
			end else begin
				send_matrix(n, ($urandom_range(0, 9) == 0) ? $urandom_range(1, pairs) : pairs);
			end
		end

		steady = 1'b0;
		settle();
		if (fail_count == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule
